// ===== hw/rtl/afl_pkg.sv =====
// Arrival flow table shared types, constants and address classifiers.
// Used by afl_cfg, afl_ctrl, afl_dp and the top level; depends on nothing.
package afl_pkg;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [15:0] WEB_PORT_RESET   = 16'd80;
  localparam logic [15:0] PROBE_PORT_RESET = 16'd4444;

  localparam logic       REG_WEB_PORT   = 1'b0;
  localparam logic       REG_PROBE_PORT = 1'b1;
  localparam int unsigned CFG_ADDR_W    = 3;

  localparam logic       ACT_RECORD  = 1'b0;
  localparam logic       ACT_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] count;
    logic [62:0] time_us;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic write_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic verdict;
    logic out_free;
  } sts_t;

  function automatic logic in_amateur_net(input logic [31:0] a);
    return ((a & 32'hFF80_0000) == 32'h2C00_0000) ||
           ((a & 32'hFFC0_0000) == 32'h2C80_0000);
  endfunction

  function automatic logic in_private_net(input logic [31:0] a);
    return ((a & 32'hFF00_0000) == 32'h0A00_0000) ||
           ((a & 32'hFFF0_0000) == 32'hAC10_0000) ||
           ((a & 32'hFFFF_0000) == 32'hC0A8_0000) ||
           ((a & 32'hFFC0_0000) == 32'h6440_0000);
  endfunction

endpackage

// ===== hw/rtl/afl_chan_if.sv =====
// Valid/ready channel interfaces for arrival and result transactions.
// Depends on nothing.
interface afl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  protocol;
  logic [31:0] source_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [62:0] now_us;

  modport source (output valid, action, protocol, source_addr, source_port, dest_port,
                  now_us, input ready);
  modport sink (input valid, action, protocol, source_addr, source_port, dest_port,
                now_us, output ready);
endinterface

interface afl_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [3:0]  slot_used;
  logic [31:0] hit_count;
  logic        web_seen;
  logic        probe_seen;
  logic        from_amateur_net;
  logic        from_routable;
  logic        newest_found;
  logic [31:0] newest_source;
  logic [62:0] newest_age_us;

  modport source (output valid, matched, slot_used, hit_count, web_seen, probe_seen,
                  from_amateur_net, from_routable, newest_found, newest_source,
                  newest_age_us, input ready);
  modport sink (input valid, matched, slot_used, hit_count, web_seen, probe_seen,
                from_amateur_net, from_routable, newest_found, newest_source,
                newest_age_us, output ready);
endinterface

// ===== hw/rtl/afl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module afl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/afl_cfg.sv =====
// APB-style configuration registers for the web and probe ports.
// Depends on afl_pkg.
module afl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  web_port,
  output logic [15:0]                  probe_port
);

  logic [15:0] web_port_r, web_port_nxt;
  logic [15:0] probe_port_r, probe_port_nxt;
  logic        wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    web_port_nxt   = web_port_r;
    probe_port_nxt = probe_port_r;
    if (wr) begin
      unique case (paddr[2])
        afl_pkg::REG_WEB_PORT:   web_port_nxt   = pwdata[15:0];
        afl_pkg::REG_PROBE_PORT: probe_port_nxt = pwdata[15:0];
        default:                 web_port_nxt   = web_port_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      web_port_r   <= afl_pkg::WEB_PORT_RESET;
      probe_port_r <= afl_pkg::PROBE_PORT_RESET;
    end else begin
      web_port_r   <= web_port_nxt;
      probe_port_r <= probe_port_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      afl_pkg::REG_WEB_PORT:   prdata = {16'd0, web_port_r};
      afl_pkg::REG_PROBE_PORT: prdata = {16'd0, probe_port_r};
      default:                 prdata = 32'd0;
    endcase
  end

  assign web_port   = web_port_r;
  assign probe_port = probe_port_r;

endmodule

// ===== hw/rtl/afl_ctrl.sv =====
// Controller state machine: accept, scan, write back (record only), deliver.
// Depends on afl_pkg.
module afl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  afl_pkg::sts_t sts,
  output afl_pkg::cmd_t cmd
);

  afl_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      afl_pkg::ST_IDLE:  if (in_valid) state_nxt = afl_pkg::ST_SCAN;
      afl_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.verdict ? afl_pkg::ST_FIN : afl_pkg::ST_WRITE;
        end
      end
      afl_pkg::ST_WRITE: state_nxt = afl_pkg::ST_FIN;
      afl_pkg::ST_FIN:   if (sts.out_free) state_nxt = afl_pkg::ST_IDLE;
      default:           state_nxt = afl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      afl_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      afl_pkg::ST_SCAN:  cmd.scan_en  = ~sts.scan_done;
      afl_pkg::ST_WRITE: cmd.write_en = 1'b1;
      afl_pkg::ST_FIN:   cmd.load_out = sts.out_free;
      default:           cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/afl_dp.sv =====
// Datapath: entry RAM, valid bits, scan compare stage, verdict accumulators,
// write back and output register. Depends on afl_pkg and afl_ram.
module afl_dp #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  afl_pkg::cmd_t cmd,
  output afl_pkg::sts_t sts,
  input  logic [15:0]   web_port,
  input  logic [15:0]   probe_port,
  input  logic          in_action,
  input  logic [7:0]    in_protocol,
  input  logic [31:0]   in_source_addr,
  input  logic [15:0]   in_source_port,
  input  logic [15:0]   in_dest_port,
  input  logic [62:0]   in_now_us,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_matched,
  output logic [3:0]    out_slot_used,
  output logic [31:0]   out_hit_count,
  output logic          out_web_seen,
  output logic          out_probe_seen,
  output logic          out_from_amateur_net,
  output logic          out_from_routable,
  output logic          out_newest_found,
  output logic [31:0]   out_newest_source,
  output logic [62:0]   out_newest_age_us
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned EW = $bits(afl_pkg::entry_t);

  // latched transaction
  logic        act_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [62:0] now_r;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IW-1:0]            ptr_r;
  logic [CW-1:0]            rd_cnt_r;
  logic                     cmp_vld_r;
  logic [IW-1:0]            cmp_idx_r;
  logic                     found_r;
  logic                     end_r;
  logic [IW-1:0]            hit_idx_r;
  afl_pkg::entry_t          hit_entry_r;
  logic [IW-1:0]            slot_hold_r;

  logic        web_r, probe_r, amateur_r, public_r;
  logic [62:0] newest_r;
  logic [31:0] newest_src_r;

  logic            rd_issue;
  logic            cmp_live;
  logic            hit;
  afl_pkg::entry_t rd_entry;
  logic [EW-1:0]   rdata;
  afl_pkg::entry_t wr_entry;
  logic [IW-1:0]   waddr;
  logic [62:0]     age;

  logic        out_valid_r;
  logic        matched_r;
  logic [3:0]  slot_r;
  logic [31:0] count_r;
  logic        web_out_r, probe_out_r, amateur_out_r, public_out_r, found_out_r;
  logic [31:0] newest_src_out_r;
  logic [62:0] age_out_r;

  assign rd_issue = cmd.scan_en & (rd_cnt_r < CW'(TABLE_ENTRIES));
  assign rd_entry = afl_pkg::entry_t'(rdata);
  assign cmp_live = cmd.scan_en & cmp_vld_r & valid_r[cmp_idx_r];
  assign hit      = (rd_entry.protocol == proto_r) && (rd_entry.source == src_r) &&
                    (rd_entry.dest_port == dport_r);

  always_comb begin
    if (found_r) begin
      waddr                = hit_idx_r;
      wr_entry             = hit_entry_r;
      wr_entry.count       = hit_entry_r.count + 32'd1;
      wr_entry.source_port = sport_r;
      wr_entry.time_us     = now_r;
    end else begin
      waddr                = ptr_r;
      wr_entry.protocol    = proto_r;
      wr_entry.source      = src_r;
      wr_entry.source_port = sport_r;
      wr_entry.dest_port   = dport_r;
      wr_entry.count       = 32'd1;
      wr_entry.time_us     = now_r;
    end
  end

  assign age = ((newest_r != '0) && (now_r > newest_r)) ? (now_r - newest_r) : '0;

  afl_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (waddr),
    .wdata (EW'(wr_entry)),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r   <= in_action;
      proto_r <= in_protocol;
      src_r   <= in_source_addr;
      sport_r <= in_source_port;
      dport_r <= in_dest_port;
      now_r   <= in_now_us;
    end
    cmp_idx_r <= rd_cnt_r[IW-1:0];
    if (cmd.start) begin
      web_r        <= 1'b0;
      probe_r      <= 1'b0;
      amateur_r    <= 1'b0;
      public_r     <= 1'b0;
      newest_r     <= '0;
      newest_src_r <= '0;
    end else if (cmp_live) begin
      if (rd_entry.protocol == afl_pkg::PROTO_TCP && rd_entry.dest_port == web_port) begin
        web_r <= 1'b1;
      end
      if (rd_entry.protocol == afl_pkg::PROTO_UDP && rd_entry.dest_port == probe_port) begin
        probe_r <= 1'b1;
      end
      if (afl_pkg::in_amateur_net(rd_entry.source)) begin
        amateur_r <= 1'b1;
      end
      if (!afl_pkg::in_private_net(rd_entry.source)) begin
        public_r <= 1'b1;
      end
      if (rd_entry.time_us > newest_r) begin
        newest_r     <= rd_entry.time_us;
        newest_src_r <= rd_entry.source;
      end
    end
    if (cmp_live && hit && !found_r && act_r == afl_pkg::ACT_RECORD) begin
      hit_idx_r   <= cmp_idx_r;
      hit_entry_r <= rd_entry;
    end
    // hold the written slot; on a new entry the replace pointer advances on the same edge
    if (cmd.write_en) begin
      slot_hold_r <= waddr;
    end
    if (cmd.load_out) begin
      if (act_r == afl_pkg::ACT_RECORD) begin
        matched_r        <= found_r;
        slot_r           <= 4'(slot_hold_r);
        count_r          <= wr_entry.count;
        web_out_r        <= 1'b0;
        probe_out_r      <= 1'b0;
        amateur_out_r    <= 1'b0;
        public_out_r     <= 1'b0;
        found_out_r      <= 1'b0;
        newest_src_out_r <= '0;
        age_out_r        <= '0;
      end else begin
        matched_r        <= 1'b0;
        slot_r           <= '0;
        count_r          <= '0;
        web_out_r        <= web_r;
        probe_out_r      <= probe_r;
        amateur_out_r    <= amateur_r;
        public_out_r     <= public_r;
        found_out_r      <= (newest_r != '0);
        newest_src_out_r <= newest_src_r;
        age_out_r        <= age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ptr_r       <= '0;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_cnt_r  <= '0;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
        end_r     <= 1'b0;
      end else begin
        if (rd_issue) begin
          rd_cnt_r <= rd_cnt_r + CW'(1);
        end
        cmp_vld_r <= rd_issue;
        if (cmp_live && hit && act_r == afl_pkg::ACT_RECORD) begin
          found_r <= 1'b1;
        end
        if (cmd.scan_en && cmp_vld_r && cmp_idx_r == IW'(TABLE_ENTRIES - 1)) begin
          end_r <= 1'b1;
        end
      end
      if (cmd.write_en && !found_r) begin
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= (ptr_r == IW'(TABLE_ENTRIES - 1)) ? '0 : ptr_r + IW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.scan_done = found_r | end_r;
  assign sts.verdict   = (act_r == afl_pkg::ACT_VERDICT);
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid            = out_valid_r;
  assign out_matched          = matched_r;
  assign out_slot_used        = slot_r;
  assign out_hit_count        = count_r;
  assign out_web_seen         = web_out_r;
  assign out_probe_seen       = probe_out_r;
  assign out_from_amateur_net = amateur_out_r;
  assign out_from_routable    = public_out_r;
  assign out_newest_found     = found_out_r;
  assign out_newest_source    = newest_src_out_r;
  assign out_newest_age_us    = age_out_r;

endmodule

// ===== hw/rtl/arrival_flow_table.sv =====
// Arrival flow table top level. A record scans the table until a match or the last entry,
// then writes back; a verdict scans every entry and skips the write back. The entry RAM is
// read one entry per cycle during the scan, and a new transaction is taken only once the
// result of the last has been loaded. A finished result waits in the output register.
// Reset: valid bits and replace pointer cleared, web port 80, probe port 4444; no
// clearing pass. Depends on afl_pkg, afl_chan_if, afl_cfg, afl_ctrl, afl_dp, afl_ram.
module arrival_flow_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  afl_in_if.sink                         in_if,
  afl_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [afl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  afl_pkg::cmd_t cmd;
  afl_pkg::sts_t sts;
  logic [15:0]   web_port;
  logic [15:0]   probe_port;
  logic          in_ready;

  assign in_if.ready = in_ready;

  afl_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .web_port   (web_port),
    .probe_port (probe_port)
  );

  afl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .web_port             (web_port),
    .probe_port           (probe_port),
    .in_action            (in_if.action),
    .in_protocol          (in_if.protocol),
    .in_source_addr       (in_if.source_addr),
    .in_source_port       (in_if.source_port),
    .in_dest_port         (in_if.dest_port),
    .in_now_us            (in_if.now_us),
    .out_valid            (out_if.valid),
    .out_ready            (out_if.ready),
    .out_matched          (out_if.matched),
    .out_slot_used        (out_if.slot_used),
    .out_hit_count        (out_if.hit_count),
    .out_web_seen         (out_if.web_seen),
    .out_probe_seen       (out_if.probe_seen),
    .out_from_amateur_net (out_if.from_amateur_net),
    .out_from_routable    (out_if.from_routable),
    .out_newest_found     (out_if.newest_found),
    .out_newest_source    (out_if.newest_source),
    .out_newest_age_us    (out_if.newest_age_us)
  );

endmodule
